// ===== src/sdb_pkg.sv =====
`default_nettype none

package sdb_pkg;

   // Default geometry of the descriptor segments
   localparam int unsigned PAGE_BYTES_DEF   = 4096;
   localparam int unsigned DESC_BYTES_DEF   = 16;
   localparam int unsigned MAX_ELEMENTS_DEF = 65536;

   // Field widths
   localparam int unsigned ADDR_W   = 64;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned CNT_W    = 17;
   localparam int unsigned SEG_W    = 9;
   localparam int unsigned SLOTO_W  = 8;
   localparam int unsigned SEGCNT_W = 10;
   localparam int unsigned PAGE_W   = 17;

   // Stream payload widths
   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 128;
   localparam int unsigned RSP_USER_W = 2;

   // Register port
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_SEG_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEM_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      KIND_DATA      = 2'd0,
      KIND_LINK      = 2'd1,
      KIND_LAST_LINK = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0] segment_base_address;
      logic [CNT_W-1:0]  element_count;
      logic [LEN_W-1:0]  expected_length;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   desc_address;
      logic [LEN_W-1:0]    desc_length;
      kind_type            desc_kind;
      logic [SEG_W-1:0]    segment_index;
      logic [SLOTO_W-1:0]  slot_index;
      logic                last_of_run;
      logic                list_done;
      logic                length_mismatch;
      logic [SEGCNT_W-1:0] segment_count;
   } descriptor_type;

   // One request's worth of descriptors: the data descriptor and an optional link
   typedef struct packed {
      logic           two;
      descriptor_type first;
      descriptor_type second;
   } pair_type;

endpackage

`default_nettype wire

// ===== src/segmented_sgl_descriptor_builder_top.sv =====
// Segmented scatter-gather descriptor builder. Each request carries one mapped
// element (address, length) and yields a data descriptor in the next slot of
// the current segment page; when the page's data slots fill and elements remain,
// a link descriptor to the next page follows in the page's last slot. A list
// starts on the first request after the previous list closed, loading
// element_count (zero count: the request is dropped with no descriptor).
// Flow: a request is held in the input register, is resolved into one or two
// descriptors that load the output register, and leaves from there. The
// output register sends one descriptor per cycle while rsp_tready is high and
// loads the next pair as the last descriptor of the held one leaves.
// Registers are to be written only while the block is idle; the block does not enforce it.
`default_nettype none

module segmented_sgl_descriptor_builder_top #(
   parameter int unsigned PAGE_BYTES   = sdb_pkg::PAGE_BYTES_DEF,
   parameter int unsigned DESC_BYTES   = sdb_pkg::DESC_BYTES_DEF,
   parameter int unsigned MAX_ELEMENTS = sdb_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // element_address [63:0], element_length [95:64]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sdb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // desc_address [63:0], desc_length [95:64], segment_index [104:96],
   // slot_index [112:105], list_done [113], length_mismatch [114],
   // segment_count [124:115], zero [127:125]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sdb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // desc_kind [1:0]
   output logic [sdb_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sdb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sdb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sdb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import sdb_pkg::*;

   cfg_type  cfg;
   pair_type pair;
   logic     pair_load;
   logic     pair_free;

   sdb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdb_core #(
      .PAGE_BYTES   (PAGE_BYTES),
      .DESC_BYTES   (DESC_BYTES),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_address (req_tdata[ADDR_W-1:0]),
      .req_length  (req_tdata[ADDR_W+LEN_W-1:ADDR_W]),
      .cfg         (cfg),
      .pair_free   (pair_free),
      .pair_load   (pair_load),
      .pair        (pair)
   );

   sdb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .pair_load  (pair_load),
      .pair       (pair),
      .pair_free  (pair_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== src/sdb_csr.sv =====
`default_nettype none

module sdb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sdb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sdb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sdb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output sdb_pkg::cfg_type                 cfg
);
   import sdb_pkg::*;

   cfg_type               cfg_ff;
   logic                  wr_en;
   logic [CSR_IDX_W-1:0]  idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         case (idx)
            CSR_SEG_BASE:   cfg_ff.segment_base_address <= csr_pwdata;
            CSR_ELEM_COUNT: cfg_ff.element_count        <= csr_pwdata[CNT_W-1:0];
            CSR_EXP_LENGTH: cfg_ff.expected_length      <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_SEG_BASE:   csr_prdata = cfg_ff.segment_base_address;
         CSR_ELEM_COUNT: csr_prdata = {{(CSR_DATA_W-CNT_W){1'b0}}, cfg_ff.element_count};
         CSR_EXP_LENGTH: csr_prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, cfg_ff.expected_length};
         default:        csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== src/sdb_core.sv =====
`default_nettype none

module sdb_core #(
   parameter int unsigned PAGE_BYTES   = sdb_pkg::PAGE_BYTES_DEF,
   parameter int unsigned DESC_BYTES   = sdb_pkg::DESC_BYTES_DEF,
   parameter int unsigned MAX_ELEMENTS = sdb_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sdb_pkg::ADDR_W-1:0]    req_address,
   input  logic [sdb_pkg::LEN_W-1:0]     req_length,
   input  sdb_pkg::cfg_type              cfg,
   input  logic                          pair_free,
   output logic                          pair_load,
   output sdb_pkg::pair_type             pair
);
   import sdb_pkg::*;

   localparam int unsigned PER        = PAGE_BYTES / DESC_BYTES;
   localparam int unsigned DATA_SLOTS = (PER < 2) ? 1 : PER - 1;
   localparam int unsigned SLOT_W     = $clog2(DATA_SLOTS + 1);
   localparam int unsigned OFF_W      = SEG_W + PAGE_W;

   // Input register
   logic              in_valid_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [LEN_W-1:0]  in_len_ff;

   // List state
   logic [CNT_W-1:0]  rem_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [SEG_W-1:0]  seg_ff;
   logic [LEN_W-1:0]  total_ff;

   logic              advance;
   logic              start;
   logic              empty;
   logic [CNT_W-1:0]  cnt_sat;
   logic [CNT_W-1:0]  eff_rem;
   logic [SLOT_W-1:0] eff_slot;
   logic [SEG_W-1:0]  eff_seg;
   logic [LEN_W-1:0]  eff_total;
   logic [CNT_W-1:0]  rem_in;
   logic [SLOT_W-1:0] slot_inc;
   logic [LEN_W-1:0]  total_in;
   logic [SEG_W-1:0]  next_seg;
   logic              done;
   logic              link;
   logic              last_link;
   logic [OFF_W-1:0]  link_off;
   logic [LEN_W-1:0]  link_len;
   logic [SLOT_W+SLOTO_W-1:0] slot_wide;
   logic [SLOT_W+SLOTO_W-1:0] dslot_wide;

   assign advance    = in_valid_ff && pair_free;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      start   = (rem_ff == '0);
      empty   = start && (cfg.element_count == '0);
      cnt_sat = (32'(cfg.element_count) > 32'(MAX_ELEMENTS)) ?
                CNT_W'(MAX_ELEMENTS) : cfg.element_count;

      eff_rem   = start ? cnt_sat : rem_ff;
      eff_slot  = start ? '0 : slot_ff;
      eff_seg   = start ? '0 : seg_ff;
      eff_total = start ? '0 : total_ff;

      total_in  = eff_total + in_len_ff;
      rem_in    = eff_rem - CNT_W'(1);
      slot_inc  = eff_slot + SLOT_W'(1);
      next_seg  = eff_seg + SEG_W'(1);

      done      = (rem_in == '0);
      link      = !done && (slot_inc >= SLOT_W'(DATA_SLOTS));
      last_link = (32'(rem_in) <= 32'(DATA_SLOTS));

      link_off  = {{PAGE_W{1'b0}}, next_seg} * OFF_W'(PAGE_BYTES);
      link_len  = last_link ? (LEN_W'(rem_in) * LEN_W'(DESC_BYTES)) : LEN_W'(PAGE_BYTES);

      slot_wide  = {{SLOTO_W{1'b0}}, eff_slot};
      dslot_wide = {{SLOTO_W{1'b0}}, SLOT_W'(DATA_SLOTS)};

      pair.two = link;

      pair.first.desc_address    = in_addr_ff;
      pair.first.desc_length     = in_len_ff;
      pair.first.desc_kind       = KIND_DATA;
      pair.first.segment_index   = eff_seg;
      pair.first.slot_index      = slot_wide[SLOTO_W-1:0];
      pair.first.last_of_run     = !link;
      pair.first.list_done       = done;
      pair.first.length_mismatch = done && (total_in != cfg.expected_length);
      pair.first.segment_count   = done ? ({1'b0, eff_seg} + SEGCNT_W'(1)) : '0;

      pair.second.desc_address    = cfg.segment_base_address
                                    + {{(ADDR_W-OFF_W){1'b0}}, link_off};
      pair.second.desc_length     = link_len;
      pair.second.desc_kind       = last_link ? KIND_LAST_LINK : KIND_LINK;
      pair.second.segment_index   = eff_seg;
      pair.second.slot_index      = dslot_wide[SLOTO_W-1:0];
      pair.second.last_of_run     = 1'b1;
      pair.second.list_done       = 1'b0;
      pair.second.length_mismatch = 1'b0;
      pair.second.segment_count   = '0;
   end

   // An empty list swallows the request without producing a descriptor
   assign pair_load = advance && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rem_ff      <= '0;
         slot_ff     <= '0;
         seg_ff      <= '0;
         total_ff    <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (pair_load) begin
            rem_ff   <= rem_in;
            total_ff <= total_in;
            if (link) begin
               seg_ff  <= next_seg;
               slot_ff <= '0;
            end else begin
               seg_ff  <= eff_seg;
               slot_ff <= slot_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_addr_ff <= req_address;
         in_len_ff  <= req_length;
      end
   end

   // A closed list may leave the slot counter at the page end; the next start ignores it
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rem_ff != '0) |-> (slot_ff < SLOT_W'(DATA_SLOTS)))
      else $error("slot counter beyond data slots");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (pair_load && done) |=> (rem_ff == '0))
      else $error("list closed but elements remain");

   a_link_resets_slot: assert property (@(posedge clock) disable iff (reset)
      (pair_load && link) |=> (slot_ff == '0))
      else $error("link emitted without moving to a fresh segment");

endmodule

`default_nettype wire

// ===== src/sdb_out.sv =====
`default_nettype none

module sdb_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pair_load,
   input  sdb_pkg::pair_type                 pair,
   output logic                              pair_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sdb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [sdb_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);
   import sdb_pkg::*;

   logic           valid_ff;
   logic           two_ff;
   logic           pos_ff;
   descriptor_type first_ff;
   descriptor_type second_ff;
   descriptor_type cur;

   // Free when no pair is held or once the final descriptor of the held pair leaves
   assign pair_free  = !valid_ff || (rsp_tready && (pos_ff || !two_ff));
   assign rsp_tvalid = valid_ff;
   assign cur        = pos_ff ? second_ff : first_ff;

   assign rsp_tdata = {{(RSP_DATA_W-ADDR_W-LEN_W-SEG_W-SLOTO_W-2-SEGCNT_W){1'b0}},
                       cur.segment_count, cur.length_mismatch, cur.list_done,
                       cur.slot_index, cur.segment_index, cur.desc_length,
                       cur.desc_address};
   assign rsp_tuser = cur.desc_kind;
   assign rsp_tlast = cur.last_of_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         two_ff   <= 1'b0;
         pos_ff   <= 1'b0;
      end else if (pair_free) begin
         valid_ff <= pair_load;
         pos_ff   <= 1'b0;
         if (pair_load) begin
            two_ff <= pair.two;
         end
      end else if (rsp_tready) begin
         pos_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pair_free && pair_load) begin
         first_ff  <= pair.first;
         second_ff <= pair.second;
      end
   end

   a_pos_needs_two: assert property (@(posedge clock) disable iff (reset)
      pos_ff |-> (valid_ff && two_ff))
      else $error("second descriptor selected without a link");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && two_ff) |-> !first_ff.last_of_run)
      else $error("data descriptor marked last ahead of its link");

endmodule

`default_nettype wire
